/* src/mono_column_framebuffer_drawer_defines.svh */
// Assertion macros for the framebuffer drawer controller.
`ifndef MONO_COLUMN_FRAMEBUFFER_DRAWER_DEFINES_SVH
`define MONO_COLUMN_FRAMEBUFFER_DRAWER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mcfd_pkg.sv */
// Types and constants shared by the framebuffer drawer modules.
package mcfd_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned COLOR_W    = 2;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned VW_W       = 8;
  localparam int unsigned VH_W       = 7;
  localparam int unsigned CO_W       = 7;
  localparam int unsigned RO_W       = 6;

  localparam logic [VW_W-1:0] VIEW_WIDTH_RST    = 8'd128;
  localparam logic [VH_W-1:0] VIEW_HEIGHT_RST   = 7'd64;
  localparam logic [CO_W-1:0] COLUMN_OFFSET_RST = 7'd0;
  localparam logic [RO_W-1:0] ROW_OFFSET_RST    = 6'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL       = 3'd0,
    CMD_READ_PIXEL  = 3'd1,
    CMD_VLINE       = 3'd2,
    CMD_HLINE       = 3'd3,
    CMD_RECT        = 3'd4,
    CMD_READ_COLUMN = 3'd5
  } cmd_e;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_CLEAR  = 2'd0,
    COLOR_SET    = 2'd1,
    COLOR_INVERT = 2'd2
  } color_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_WIDTH    = 2'd0,
    CFG_VIEW_HEIGHT   = 2'd1,
    CFG_COLUMN_OFFSET = 2'd2,
    CFG_ROW_OFFSET    = 2'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the input item
    logic prep;      // bounds check, mask and column range
    logic rd_issue;  // single column read
    logic sweep;     // read-modify-write sweep over the column range
    logic load_out;  // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ok;
    logic is_read;
    logic sweep_done;
  } dp_status_t;

endpackage

/* src/mcfd_cmd_if.sv */
// Command channel: drawing command item with valid/ready.
interface mcfd_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [mcfd_pkg::CMD_W-1:0]   command;
  logic [mcfd_pkg::COORD_W-1:0] x_start;
  logic [mcfd_pkg::COORD_W-1:0] y_start;
  logic [mcfd_pkg::COORD_W-1:0] x_end;
  logic [mcfd_pkg::COORD_W-1:0] y_end;
  logic [mcfd_pkg::COLOR_W-1:0] color;

  modport source (output valid, command, x_start, y_start, x_end, y_end, color,
                  input ready);
  modport sink (input valid, command, x_start, y_start, x_end, y_end, color,
                output ready);
endinterface

/* src/mcfd_res_if.sv */
// Result channel: command result item with valid/ready.
interface mcfd_res_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        pixel_value;
  logic [mcfd_pkg::WORD_W-1:0] column_word;

  modport source (output valid, accepted, pixel_value, column_word, input ready);
  modport sink (input valid, accepted, pixel_value, column_word, output ready);
endinterface

/* src/mcfd_ctrl.sv */
// Controller state machine for the framebuffer drawer.
`include "mono_column_framebuffer_drawer_defines.svh"

module mcfd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mcfd_pkg::ctrl_cmd_t  cmd_o,
  input  mcfd_pkg::dp_status_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_SWEEP,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prep     = (state_q == S_CHECK);
    cmd_o.rd_issue = (state_q == S_READ);
    cmd_o.sweep    = (state_q == S_SWEEP);
    cmd_o.load_out = (state_q == S_RESP) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.ok) state_d = S_RESP;
        else if (sts_i.is_read) state_d = S_READ;
        else state_d = S_SWEEP;
      end
      S_READ: begin
        state_d = S_RESP;
      end
      S_SWEEP: begin
        if (sts_i.sweep_done) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  `MCFD_ASSERT_NEXT(a_accept_to_check, in_ready_o && in_valid_i, state_q == S_CHECK, "accepted item did not enter bounds check")
  `MCFD_ASSERT_NEXT(a_sweep_to_resp, (state_q == S_SWEEP) && sts_i.sweep_done, state_q == S_RESP, "finished sweep did not move to result")
  `MCFD_ASSERT_NEXT(a_resp_loads_out, (state_q == S_RESP) && out_free, out_valid_q && (state_q == S_IDLE), "result not presented after result state")
  `MCFD_ASSERT_SAME(a_sweep_in_bounds, state_q == S_SWEEP, sts_i.ok, "sweep running on a rejected item")

endmodule

/* src/mcfd_dp.sv */
// Datapath for the framebuffer drawer: item and config registers, column store, result.
module mcfd_dp #(
  parameter int unsigned MAX_COLUMNS  = 128,
  parameter int unsigned COLUMN_BYTES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcfd_pkg::ctrl_cmd_t               cmd_i,
  output mcfd_pkg::dp_status_t              sts_o,
  input  logic [mcfd_pkg::CMD_W-1:0]        command_i,
  input  logic [mcfd_pkg::COORD_W-1:0]      x_start_i,
  input  logic [mcfd_pkg::COORD_W-1:0]      y_start_i,
  input  logic [mcfd_pkg::COORD_W-1:0]      x_end_i,
  input  logic [mcfd_pkg::COORD_W-1:0]      y_end_i,
  input  logic [mcfd_pkg::COLOR_W-1:0]      color_i,
  input  logic                              cfg_we_i,
  input  logic [mcfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              accepted_o,
  output logic                              pixel_value_o,
  output logic [mcfd_pkg::WORD_W-1:0]       column_word_o
);

  localparam int unsigned ROW_BITS  = COLUMN_BYTES * 8;
  localparam int unsigned ROW_IDX_W = $clog2(ROW_BITS);
  localparam int unsigned COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned SUM_W     = mcfd_pkg::COORD_W + 1;
  localparam logic [SUM_W-1:0]     COL_LIMIT = SUM_W'(MAX_COLUMNS);
  localparam logic [SUM_W-1:0]     ROW_LIMIT = SUM_W'(ROW_BITS);
  localparam logic [ROW_IDX_W-1:0] ROW_TOP   = ROW_IDX_W'(ROW_BITS - 1);

  // Configuration registers
  logic [mcfd_pkg::VW_W-1:0] vw_q;
  logic [mcfd_pkg::VH_W-1:0] vh_q;
  logic [mcfd_pkg::CO_W-1:0] co_q;
  logic [mcfd_pkg::RO_W-1:0] ro_q;

  // Latched item
  logic [mcfd_pkg::CMD_W-1:0]   cmd_q;
  logic [mcfd_pkg::COORD_W-1:0] xs_q, ys_q, xe_q, ye_q;
  logic [mcfd_pkg::COLOR_W-1:0] color_q;

  // Prepared operation
  logic                 ok_q;
  logic [ROW_BITS-1:0]  mask_q;
  logic [ROW_IDX_W-1:0] bit_q;
  logic [COL_W-1:0]     cur_q, last_q, pend_addr_q;
  logic                 iss_q, pend_q;

  // Column store with per-entry valid bits
  logic [ROW_BITS-1:0]  mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] vld_q;
  logic [ROW_BITS-1:0]  rd_data_q;
  logic                 rd_vld_q;

  // Result register
  logic                        acc_q, pix_q;
  logic [mcfd_pkg::WORD_W-1:0] word_q;

  logic [SUM_W-1:0]     xs_sum, xe_sum, ys_sum, ye_sum;
  logic                 xs_ok, xe_ok, ys_ok, ye_ok, ok_s;
  logic [COL_W-1:0]     first_col, last_col;
  logic [ROW_IDX_W-1:0] lo_row, hi_row;
  logic [ROW_BITS-1:0]  mask_s, rd_word, new_word;
  logic                 rd_en, wr_en;

  // Bounds and column range
  always_comb begin
    xs_sum = SUM_W'(xs_q) + SUM_W'(co_q);
    xe_sum = SUM_W'(xe_q) + SUM_W'(co_q);
    ys_sum = SUM_W'(ys_q) + SUM_W'(ro_q);
    ye_sum = SUM_W'(ye_q) + SUM_W'(ro_q);
    xs_ok  = (xs_q < vw_q) && (xs_sum < COL_LIMIT);
    xe_ok  = (xe_q < vw_q) && (xe_sum < COL_LIMIT);
    ys_ok  = (ys_q < mcfd_pkg::COORD_W'(vh_q)) && (ys_sum < ROW_LIMIT);
    ye_ok  = (ye_q < mcfd_pkg::COORD_W'(vh_q)) && (ye_sum < ROW_LIMIT);

    ok_s      = 1'b0;
    first_col = xs_sum[COL_W-1:0];
    last_col  = xs_sum[COL_W-1:0];
    lo_row    = ys_sum[ROW_IDX_W-1:0];
    hi_row    = ys_sum[ROW_IDX_W-1:0];
    case (cmd_q) inside
      mcfd_pkg::CMD_PIXEL, mcfd_pkg::CMD_READ_PIXEL: begin
        ok_s = xs_ok && ys_ok;
      end
      mcfd_pkg::CMD_VLINE: begin
        ok_s   = xs_ok && ys_ok && ye_ok && (ye_q >= ys_q);
        hi_row = ye_sum[ROW_IDX_W-1:0];
      end
      mcfd_pkg::CMD_HLINE: begin
        ok_s     = xs_ok && xe_ok && (xe_q >= xs_q) && ys_ok;
        last_col = xe_sum[COL_W-1:0];
      end
      mcfd_pkg::CMD_RECT: begin
        ok_s     = xs_ok && xe_ok && (xe_q >= xs_q) && ys_ok && ye_ok && (ye_q >= ys_q);
        last_col = xe_sum[COL_W-1:0];
        hi_row   = ye_sum[ROW_IDX_W-1:0];
      end
      mcfd_pkg::CMD_READ_COLUMN: begin
        ok_s = xs_ok;
      end
      default: begin
        ok_s = 1'b0;
      end
    endcase

    mask_s = ({ROW_BITS{1'b1}} >> (ROW_TOP - hi_row)) & ({ROW_BITS{1'b1}} << lo_row);
  end

  always_comb begin
    sts_o            = '0;
    sts_o.ok         = ok_s;
    sts_o.is_read    = (cmd_q == mcfd_pkg::CMD_READ_PIXEL) ||
                       (cmd_q == mcfd_pkg::CMD_READ_COLUMN);
    sts_o.sweep_done = !iss_q && !pend_q;
  end

  // Store access: read the current column, write back the previous one
  assign rd_en   = cmd_i.rd_issue || (cmd_i.sweep && iss_q);
  assign wr_en   = cmd_i.sweep && pend_q;
  assign rd_word = rd_vld_q ? rd_data_q : '0;

  always_comb begin
    case (color_q)
      mcfd_pkg::COLOR_CLEAR: new_word = rd_word & ~mask_q;
      mcfd_pkg::COLOR_SET:   new_word = rd_word | mask_q;
      default:               new_word = rd_word ^ mask_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[pend_addr_q] <= new_word;
    if (rd_en) rd_data_q <= mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) vld_q[pend_addr_q] <= 1'b1;
      if (rd_en) rd_vld_q <= vld_q[cur_q];
    end
  end

  // Column sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q       <= 1'b0;
      pend_q      <= 1'b0;
      cur_q       <= '0;
      last_q      <= '0;
      pend_addr_q <= '0;
    end else if (cmd_i.prep) begin
      iss_q  <= 1'b1;
      pend_q <= 1'b0;
      cur_q  <= first_col;
      last_q <= last_col;
    end else if (cmd_i.sweep) begin
      pend_q <= iss_q;
      if (iss_q) begin
        pend_addr_q <= cur_q;
        if (cur_q == last_q) iss_q <= 1'b0;
        else cur_q <= cur_q + COL_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= command_i;
      xs_q    <= x_start_i;
      ys_q    <= y_start_i;
      xe_q    <= x_end_i;
      ye_q    <= y_end_i;
      color_q <= color_i;
    end
    if (cmd_i.prep) begin
      ok_q   <= ok_s;
      mask_q <= mask_s;
      bit_q  <= lo_row;
    end
    if (cmd_i.load_out) begin
      acc_q  <= ok_q;
      pix_q  <= ok_q && (cmd_q == mcfd_pkg::CMD_READ_PIXEL) && rd_word[bit_q];
      word_q <= (ok_q && (cmd_q == mcfd_pkg::CMD_READ_COLUMN)) ?
                mcfd_pkg::WORD_W'(rd_word) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= mcfd_pkg::VIEW_WIDTH_RST;
      vh_q <= mcfd_pkg::VIEW_HEIGHT_RST;
      co_q <= mcfd_pkg::COLUMN_OFFSET_RST;
      ro_q <= mcfd_pkg::ROW_OFFSET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcfd_pkg::CFG_VIEW_WIDTH:    vw_q <= cfg_data_i[mcfd_pkg::VW_W-1:0];
        mcfd_pkg::CFG_VIEW_HEIGHT:   vh_q <= cfg_data_i[mcfd_pkg::VH_W-1:0];
        mcfd_pkg::CFG_COLUMN_OFFSET: co_q <= cfg_data_i[mcfd_pkg::CO_W-1:0];
        mcfd_pkg::CFG_ROW_OFFSET:    ro_q <= cfg_data_i[mcfd_pkg::RO_W-1:0];
        default: ;
      endcase
    end
  end

  assign accepted_o    = acc_q;
  assign pixel_value_o = pix_q;
  assign column_word_o = word_q;

endmodule

/* src/mono_column_framebuffer_drawer.sv */
// Top level of the monochrome column framebuffer drawer.
//
//   channel  | dir | transfer when        | payload
//   ---------+-----+----------------------+------------------------------------------
//   cmd_i    | in  | valid && ready       | command, x/y start, x/y end, color
//   res_o    | out | valid && ready       | accepted, pixel_value, column_word
//   cfg      | in  | cfg_we_i high        | cfg_idx_i selects register, cfg_data_i
//
// A rejected command goes from the bounds check straight to the result, a pixel or
// column read issues a single store read first, and a draw command sweeps the
// stored columns it touches: the sweep reads one column and writes back the
// previous one each cycle through the single store port pair.
// Reset clears every pixel at once through per-column valid bits; no
// clearing pass follows reset.
// A result held by a stalled sink does not block the next command transfer;
// only the next result waits until the output register is free.
module mono_column_framebuffer_drawer #(
  parameter int unsigned MAX_COLUMNS  = 128,
  parameter int unsigned COLUMN_BYTES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mcfd_cmd_if.sink                        cmd_i,
  mcfd_res_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [mcfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcfd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Command and status between the controller and the datapath
  mcfd_pkg::ctrl_cmd_t  ctrl_cmd;
  mcfd_pkg::dp_status_t dp_sts;

  // Controller: hold the sequence check, read or sweep, then result
  mcfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (ctrl_cmd),
    .sts_i       (dp_sts)
  );

  // Datapath: latch the item, check bounds, sweep the store, build the result
  mcfd_dp #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .COLUMN_BYTES (COLUMN_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .sts_o         (dp_sts),
    .command_i     (cmd_i.command),
    .x_start_i     (cmd_i.x_start),
    .y_start_i     (cmd_i.y_start),
    .x_end_i       (cmd_i.x_end),
    .y_end_i       (cmd_i.y_end),
    .color_i       (cmd_i.color),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accepted_o    (res_o.accepted),
    .pixel_value_o (res_o.pixel_value),
    .column_word_o (res_o.column_word)
  );

endmodule
